// ===== design/wpi_pkg.sv =====
// shared types, field widths and command codes of the waypoint ramp interpolator
package wpi_pkg;

    // field widths
    localparam int VAL_W   = 32;
    localparam int TIME_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int LEGS_W  = 5;
    localparam int IDX_W   = 4;
    localparam int CMD_W   = 2;

    // largest number of legs or channels an index field can address
    localparam int IDX_SPAN = 2 ** IDX_W;

    // stream payload widths, whole bytes
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;

    // progress value that stands for one, q1.16 held in 17 bits
    localparam logic [FRAC_W:0] PROG_ONE = (FRAC_W + 1)'(1) << FRAC_W;

    // input transaction kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_START  = 2'd0,
        CMD_LOAD_TIMING = 2'd1,
        CMD_LOAD_TARGET = 2'd2,
        CMD_TICK        = 2'd3
    } cmd_t;

    // request to the progress divider
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] ramp;
    } div_req_t;

    // answer of the progress divider
    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/wpi_divider.sv =====
// restoring divider giving the fractional progress elapsed / ramp, one bit a cycle
module wpi_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  wpi_pkg::div_req_t req,
    output wpi_pkg::div_rsp_t rsp
);
    import wpi_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] dvs_reg;
    logic [FRAC_W-1:0] quo_reg;

    logic [TIME_W:0]   rem_dbl;
    logic [TIME_W:0]   rem_sub;
    logic              fits;

    // one quotient bit: double the remainder and try the divisor
    always_comb begin
        rem_dbl = {rem_reg, 1'b0};
        rem_sub = rem_dbl - {1'b0, dvs_reg};
        fits    = (rem_dbl >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.elapsed;
            dvs_reg <= req.ramp;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[TIME_W-1:0] : rem_dbl[TIME_W-1:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
        end
    end

    always_comb begin
        rsp.done     = done_reg;
        rsp.quotient = quo_reg;
    end

endmodule

// ===== design/waypoint_ramp_interpolator_core.sv =====
// top level of the waypoint ramp interpolator: leg walk, progress and per-channel blend
//
// channel   direction  handshake             payload
// s_        in         s_tvalid / s_tready   s_tdata: loads and ticks, s_tuser: command
// m_        out        m_tvalid / m_tready   m_tdata: channel and drive, m_tlast: last
// cfg_      in         cfg_valid / cfg_ready cfg_data: legs_in_use
//
// a load transaction writes the memories directly and leaves the input open; a tick walks
// up to L legs in the timing memory, one read and one compare each, then, when a leg is
// active, prepares the progress and, when it needs one, runs a division, and passes C =
// min(CHANNELS,16) channels through the blend pipeline one at a time.
// after reset the state, legs_in_use and the result valid are cleared; the memories hold nothing until loaded.
// s_tready is low while a tick is under way; a full result register stalls the blend.
module waypoint_ramp_interpolator_core #(
    parameter int CHANNELS = 16,
    parameter int MAX_LEGS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // leg_index[3:0], channel_index[7:4], set_value[39:8], leg_end[71:40],
    // leg_ramp[103:72], now[135:104]
    input  logic [wpi_pkg::S_TDATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [wpi_pkg::CMD_W-1:0]        s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // channel[3:0], drive[35:4], zero[39:36]
    output logic [wpi_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    // legs_in_use register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wpi_pkg::LEGS_W-1:0]       cfg_data
);
    import wpi_pkg::*;

    // storage geometry
    localparam int CH_DEPTH  = (CHANNELS < IDX_SPAN) ? CHANNELS : IDX_SPAN;
    localparam int CH_AW     = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;
    localparam int LEG_DEPTH = (MAX_LEGS < IDX_SPAN) ? MAX_LEGS : IDX_SPAN;
    localparam int LEG_AW    = (LEG_DEPTH > 1) ? $clog2(LEG_DEPTH) : 1;
    localparam int ROWS      = LEG_DEPTH + 1;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int VAL_DEPTH = ROWS * (2 ** CH_AW);
    localparam int LEGS_MAX  = (2 ** LEGS_W) - 1;

    // arithmetic widths
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROG_W = FRAC_W + 2;
    localparam int PROD_W = DIFF_W + PROG_W;
    localparam int STEP_W = PROD_W - FRAC_W;

    localparam logic [LEGS_W-1:0] NLEG_CAP =
        LEGS_W'((MAX_LEGS > LEGS_MAX) ? LEGS_MAX : MAX_LEGS);
    localparam logic [CH_AW-1:0] CH_LAST = CH_AW'(CH_DEPTH - 1);
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_W - 1);
    localparam logic signed [STEP_W-1:0] SAT_MAX =
        {{(STEP_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [STEP_W-1:0] SAT_MIN =
        {{(STEP_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_PREP,
        ST_DIV,
        ST_CH_RD,
        ST_CH_DIFF,
        ST_CH_MUL,
        ST_CH_OUT
    } state_t;

    // input fields
    cmd_t              s_cmd;
    logic [IDX_W-1:0]  leg_index;
    logic [IDX_W-1:0]  channel_index;
    logic [VAL_W-1:0]  set_value;
    logic [TIME_W-1:0] leg_end;
    logic [TIME_W-1:0] leg_ramp;
    logic [TIME_W-1:0] now;

    assign s_cmd         = cmd_t'(s_tuser);
    assign leg_index     = s_tdata[3:0];
    assign channel_index = s_tdata[7:4];
    assign set_value     = s_tdata[39:8];
    assign leg_end       = s_tdata[71:40];
    assign leg_ramp      = s_tdata[103:72];
    assign now           = s_tdata[135:104];

    // registers
    state_t                   state_reg;
    logic [LEGS_W-1:0]        cfg_legs_reg;
    logic [LEGS_W-1:0]        k_reg;
    logic [LEGS_W-1:0]        prev_leg_reg;
    logic                     have_prev_reg;
    logic                     active_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [TIME_W-1:0]        prev_end_reg;
    logic [TIME_W-1:0]        ramp_reg;
    logic [TIME_W-1:0]        elapsed_reg;
    logic [FRAC_W:0]          prog_reg;
    logic                     div_start_reg;
    logic [CH_AW-1:0]         c_reg;
    logic signed [VAL_W-1:0]  a_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_chan_reg;
    logic [VAL_W-1:0]         m_drive_reg;
    logic                     m_last_reg;

    // memories and their registered read data
    logic [2*TIME_W-1:0]      tim_mem [LEG_DEPTH];
    logic [VAL_W-1:0]         val_mem [VAL_DEPTH];
    logic [2*TIME_W-1:0]      tim_rd_reg;
    logic [VAL_W-1:0]         val_a_reg;
    logic [VAL_W-1:0]         val_b_reg;

    // handshakes
    logic s_acc;
    logic out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // result register load
    logic out_load;
    assign out_load = (state_reg == ST_CH_OUT) && out_free;

    // clamp of the leg count
    logic [LEGS_W-1:0] nlegs;
    assign nlegs = (cfg_legs_reg > NLEG_CAP) ? NLEG_CAP : cfg_legs_reg;

    // load decode
    logic              ch_ok;
    logic              leg_ok;
    logic              tim_we;
    logic              val_we;
    logic [ROW_AW-1:0] wr_row;

    always_comb begin
        ch_ok  = (int'(channel_index) < CHANNELS);
        leg_ok = (int'(leg_index) < MAX_LEGS);
        tim_we = s_acc && (s_cmd == CMD_LOAD_TIMING) && leg_ok;
        val_we = s_acc && ch_ok &&
                 ((s_cmd == CMD_LOAD_START) || ((s_cmd == CMD_LOAD_TARGET) && leg_ok));
        wr_row = (s_cmd == CMD_LOAD_START) ? '0
                 : ROW_AW'(leg_index[LEG_AW-1:0]) + ROW_AW'(1);
    end

    // read addresses: row 0 holds the start vector, row n+1 the targets of leg n
    logic [ROW_AW-1:0] from_row;
    logic [ROW_AW-1:0] to_row;

    always_comb begin
        from_row = have_prev_reg ? ROW_AW'(prev_leg_reg[LEG_AW-1:0]) + ROW_AW'(1) : '0;
        to_row   = ROW_AW'(k_reg[LEG_AW-1:0]) + ROW_AW'(1);
    end

    // timing memory: end time low, ramp high
    always_ff @(posedge aclk) begin
        if (tim_we) begin
            tim_mem[leg_index[LEG_AW-1:0]] <= {leg_ramp, leg_end};
        end
        if (state_reg == ST_WALK_RD) begin
            tim_rd_reg <= tim_mem[k_reg[LEG_AW-1:0]];
        end
    end

    // value memory: start vector and leg targets, two read ports
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[{wr_row, channel_index[CH_AW-1:0]}] <= set_value;
        end
        if (state_reg == ST_CH_RD) begin
            val_a_reg <= val_mem[{from_row, c_reg}];
            val_b_reg <= val_mem[{to_row, c_reg}];
        end
    end

    // timing fields of the leg under test
    logic [TIME_W-1:0] tim_end;
    logic [TIME_W-1:0] tim_ramp;
    assign tim_end  = tim_rd_reg[TIME_W-1:0];
    assign tim_ramp = tim_rd_reg[2*TIME_W-1:TIME_W];

    // elapsed time since the previous end, borrow means now is earlier
    logic [TIME_W:0] elapsed_full;
    assign elapsed_full = {1'b0, now_reg} - {1'b0, prev_end_reg};

    // rounding and saturation of the blended value
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [STEP_W-1:0] step;
    logic signed [STEP_W-1:0] blend_sum;
    logic [VAL_W-1:0]         drive_sat;

    always_comb begin
        prod_rnd  = prod_reg + ROUND_BIAS;
        step      = prod_rnd[PROD_W-1:FRAC_W];
        blend_sum = {{(STEP_W - VAL_W){a_reg[VAL_W-1]}}, a_reg} + step;
        if (blend_sum > SAT_MAX) begin
            drive_sat = SAT_MAX[VAL_W-1:0];
        end else if (blend_sum < SAT_MIN) begin
            drive_sat = SAT_MIN[VAL_W-1:0];
        end else begin
            drive_sat = blend_sum[VAL_W-1:0];
        end
    end

    // progress divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_comb begin
        div_req.start   = div_start_reg;
        div_req.elapsed = elapsed_reg;
        div_req.ramp    = ramp_reg;
    end

    wpi_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_legs_reg  <= '0;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                cfg_legs_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_acc && (s_cmd == CMD_TICK)) begin
                        now_reg       <= now;
                        k_reg         <= '0;
                        prev_leg_reg  <= '0;
                        have_prev_reg <= 1'b0;
                        prev_end_reg  <= '0;
                        c_reg         <= '0;
                        if (nlegs == '0) begin
                            active_reg <= 1'b0;
                            prog_reg   <= '0;
                            state_reg  <= ST_CH_RD;
                        end else begin
                            state_reg  <= ST_WALK_RD;
                        end
                    end
                end

                ST_WALK_RD: begin
                    state_reg <= ST_WALK_CHK;
                end

                // first leg whose end lies after now becomes the active one
                ST_WALK_CHK: begin
                    if (now_reg < tim_end) begin
                        active_reg <= 1'b1;
                        ramp_reg   <= tim_ramp;
                        state_reg  <= ST_PREP;
                    end else begin
                        prev_end_reg  <= tim_end;
                        prev_leg_reg  <= k_reg;
                        have_prev_reg <= 1'b1;
                        if ((k_reg + LEGS_W'(1)) == nlegs) begin
                            active_reg <= 1'b0;
                            prog_reg   <= '0;
                            state_reg  <= ST_CH_RD;
                        end else begin
                            k_reg     <= k_reg + LEGS_W'(1);
                            state_reg <= ST_WALK_RD;
                        end
                    end
                end

                // progress: zero before the previous end, one once the ramp is over, else elapsed / ramp
                ST_PREP: begin
                    elapsed_reg <= elapsed_full[TIME_W-1:0];
                    if (elapsed_full[TIME_W]) begin
                        prog_reg  <= '0;
                        state_reg <= ST_CH_RD;
                    end else if ((ramp_reg == '0) ||
                                 (elapsed_full[TIME_W-1:0] >= ramp_reg)) begin
                        prog_reg  <= PROG_ONE;
                        state_reg <= ST_CH_RD;
                    end else begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end

                ST_DIV: begin
                    if (div_rsp.done) begin
                        prog_reg  <= {1'b0, div_rsp.quotient};
                        state_reg <= ST_CH_RD;
                    end
                end

                ST_CH_RD: begin
                    state_reg <= ST_CH_DIFF;
                end

                // distance to the target, zero when every leg has ended
                ST_CH_DIFF: begin
                    a_reg <= $signed(val_a_reg);
                    if (active_reg) begin
                        diff_reg <= $signed({val_b_reg[VAL_W-1], val_b_reg}) -
                                    $signed({val_a_reg[VAL_W-1], val_a_reg});
                    end else begin
                        diff_reg <= '0;
                    end
                    state_reg <= ST_CH_MUL;
                end

                ST_CH_MUL: begin
                    prod_reg  <= diff_reg * $signed({1'b0, prog_reg});
                    state_reg <= ST_CH_OUT;
                end

                // hand the result over once the output register is free
                ST_CH_OUT: begin
                    if (out_free) begin
                        m_chan_reg  <= IDX_W'(c_reg);
                        m_drive_reg <= drive_sat;
                        m_last_reg  <= (c_reg == CH_LAST);
                        if (c_reg == CH_LAST) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            c_reg     <= c_reg + CH_AW'(1);
                            state_reg <= ST_CH_RD;
                        end
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result stream
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - VAL_W - IDX_W){1'b0}}, m_drive_reg, m_chan_reg};

endmodule

// ===== design/wpi_checker.sv =====
// port-level checks on the waypoint ramp interpolator and their binding
module wpi_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [wpi_pkg::CMD_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wpi_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import wpi_pkg::*;

    // a run still being delivered keeps the input closed
    a_run_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready
    ) else $error("input open while a tick run is being delivered");

    // an accepted tick occupies the block
    a_tick_busy: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_TICK)) |=> !s_tready
    ) else $error("input still open after a tick transaction");

    // loads never stall the input
    a_load_no_stall: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser != CMD_TICK)) |=> s_tready
    ) else $error("input closed after a load transaction");

    // a stalled result holds
    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    ) else $error("result changed while stalled");

endmodule

bind waypoint_ramp_interpolator_core wpi_checker u_wpi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
